### sv/midtt_pkg.sv
package midtt_pkg;

    localparam int ID_W     = 16;
    localparam int LEN_W    = 4;
    localparam int REFS_W   = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;
    localparam int IN_TOK_W = 64;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RETX     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    localparam logic [REFS_W-1:0] REFS_MAX = 8'hFF;
    localparam logic [REFS_W-1:0] REFS_ONE = 8'd1;

    typedef struct packed {
        logic            id_seen;
        logic            tok_seen;
        logic            tok_same;
        logic            rm;
        logic [ID_W-1:0] hit_id;
    } t_chain;

    typedef struct packed {
        logic            cmp;
        logic            upd;
        logic [OP_W-1:0] op;
        logic            full;
        logic            any_id;
    } t_ctl;

endpackage

### sv/midtt_cell.sv
module midtt_cell #(
    parameter int TW = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  midtt_pkg::t_ctl          i_ctl,
    input  logic [midtt_pkg::ID_W-1:0]   i_key_id,
    input  logic [TW-1:0]                i_key_tok,
    input  logic [midtt_pkg::LEN_W-1:0]  i_key_len,
    input  midtt_pkg::t_chain        i_chain,
    output midtt_pkg::t_chain        o_chain,
    input  logic                         i_l_valid,
    input  logic [midtt_pkg::ID_W-1:0]   i_l_id,
    input  logic [TW-1:0]                i_l_tok,
    input  logic [midtt_pkg::LEN_W-1:0]  i_l_len,
    input  logic [midtt_pkg::REFS_W-1:0] i_l_refs,
    input  logic                         i_r_valid,
    input  logic [midtt_pkg::ID_W-1:0]   i_r_id,
    input  logic [TW-1:0]                i_r_tok,
    input  logic [midtt_pkg::LEN_W-1:0]  i_r_len,
    input  logic [midtt_pkg::REFS_W-1:0] i_r_refs,
    output logic                         o_valid,
    output logic [midtt_pkg::ID_W-1:0]   o_id,
    output logic [TW-1:0]                o_tok,
    output logic [midtt_pkg::LEN_W-1:0]  o_len,
    output logic [midtt_pkg::REFS_W-1:0] o_refs
);
    import midtt_pkg::*;

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [TW-1:0]     r_tok;
    logic [LEN_W-1:0]  r_len;
    logic [REFS_W-1:0] r_refs;
    logic              r_id_eq;
    logic              r_tok_eq;
    logic              first_id;
    logic              first_tok;
    logic              take_right;

    assign first_id  = r_id_eq & ~i_chain.id_seen;
    assign first_tok = r_tok_eq & ~i_chain.tok_seen;

    always_comb begin
        o_chain.id_seen  = i_chain.id_seen | r_id_eq;
        o_chain.tok_seen = i_chain.tok_seen | r_tok_eq;
        o_chain.tok_same = i_chain.id_seen ? i_chain.tok_same : (r_id_eq & r_tok_eq);
        o_chain.rm       = i_chain.tok_seen ? i_chain.rm : (r_tok_eq && r_refs <= REFS_ONE);
        o_chain.hit_id   = i_chain.tok_seen ? i_chain.hit_id : (r_tok_eq ? r_id : '0);
    end

    assign take_right = (i_ctl.op == OP_RELEASE) & o_chain.tok_seen & o_chain.rm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_eq  <= 1'b0;
            r_tok_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_id_eq  <= r_valid && r_id == i_key_id;
            r_tok_eq <= r_valid && r_len == i_key_len && r_tok == i_key_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.upd) begin
            if (i_ctl.op == OP_INSERT && !i_ctl.any_id && !i_ctl.full) begin
                r_valid <= i_l_valid;
            end else if (take_right) begin
                r_valid <= i_r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            if (i_ctl.op == OP_INSERT) begin
                if (i_ctl.any_id) begin
                    if (first_id) begin
                        if (r_tok_eq) begin
                            if (r_refs != REFS_MAX) begin
                                r_refs <= r_refs + REFS_ONE;
                            end
                        end else begin
                            r_tok  <= i_key_tok;
                            r_len  <= i_key_len;
                            r_refs <= REFS_ONE;
                        end
                    end
                end else if (!i_ctl.full) begin
                    r_id   <= i_l_id;
                    r_tok  <= i_l_tok;
                    r_len  <= i_l_len;
                    r_refs <= i_l_refs;
                end
            end else if (take_right) begin
                r_id   <= i_r_id;
                r_tok  <= i_r_tok;
                r_len  <= i_r_len;
                r_refs <= i_r_refs;
            end else if (i_ctl.op == OP_RELEASE && first_tok) begin
                r_refs <= r_refs - REFS_ONE;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_tok   = r_tok;
    assign o_len   = r_len;
    assign o_refs  = r_refs;

endmodule

### sv/message_id_token_table_core.sv
// Table of up to TABLE_DEPTH message IDs, each with a token and a reference count, kept
// newest first in a row of cells. An item passes a compare state, in which every cell compares
// its entry with the key, and then an update state, in which the match resolves along the cell
// row and every cell updates, shifts toward the back on a new insert or toward the front on a
// removal. The next item is taken in the update state of the current one, not in its compare
// state; the update state waits while the result register still holds an untaken result.
module message_id_token_table_core #(
    parameter int TABLE_DEPTH     = 16,
    parameter int MAX_TOKEN_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [midtt_pkg::OP_W-1:0]       i_op,
    input  logic [midtt_pkg::ID_W-1:0]       i_msg_id,
    input  logic [midtt_pkg::IN_TOK_W-1:0]   i_token_bytes,
    input  logic [midtt_pkg::LEN_W-1:0]      i_token_len,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [midtt_pkg::STATUS_W-1:0]   o_status,
    output logic [midtt_pkg::ID_W-1:0]       o_found_id,
    output logic [midtt_pkg::OCC_W-1:0]      o_occupancy
);
    import midtt_pkg::*;

    localparam int TW = 8 * MAX_TOKEN_BYTES;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [OP_W-1:0]     r_op;
    logic [ID_W-1:0]     r_id;
    logic [TW-1:0]       r_tok;
    logic [TW-1:0]       n_tok;
    logic [LEN_W-1:0]    r_len;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [ID_W-1:0]     r_found_id;
    logic [ID_W-1:0]     n_found_id;
    logic [OCC_W-1:0]    r_occ;
    logic                go;
    logic                accept;
    t_ctl                ctl;
    t_chain              chain_end;

    t_chain              w_chain [TABLE_DEPTH+1];
    logic                w_valid [TABLE_DEPTH];
    logic [ID_W-1:0]     w_id    [TABLE_DEPTH];
    logic [TW-1:0]       w_tok   [TABLE_DEPTH];
    logic [LEN_W-1:0]    w_len   [TABLE_DEPTH];
    logic [REFS_W-1:0]   w_refs  [TABLE_DEPTH];

    assign go      = (r_state == S_UPD) && (!r_out_valid || !i_stall);
    assign o_stall = (r_state == S_CMP) || ((r_state == S_UPD) && !go);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_tok = '0;
        for (int b = 0; b < MAX_TOKEN_BYTES; b++) begin
            if (LEN_W'(b) < i_token_len) begin
                n_tok[8*b +: 8] = i_token_bytes[8*b +: 8];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (go) n_state = i_valid ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl.cmp    = (r_state == S_CMP);
        ctl.upd    = go;
        ctl.op     = r_op;
        ctl.full   = (r_count == CW'(TABLE_DEPTH));
        ctl.any_id = chain_end.id_seen;
    end

    assign w_chain[0] = '0;
    assign chain_end  = w_chain[TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic              l_valid;
        logic [ID_W-1:0]   l_id;
        logic [TW-1:0]     l_tok;
        logic [LEN_W-1:0]  l_len;
        logic [REFS_W-1:0] l_refs;
        logic              rt_valid;
        logic [ID_W-1:0]   rt_id;
        logic [TW-1:0]     rt_tok;
        logic [LEN_W-1:0]  rt_len;
        logic [REFS_W-1:0] rt_refs;

        if (g == 0) begin : g_head
            assign l_valid = 1'b1;
            assign l_id    = r_id;
            assign l_tok   = r_tok;
            assign l_len   = r_len;
            assign l_refs  = REFS_ONE;
        end else begin : g_mid
            assign l_valid = w_valid[g-1];
            assign l_id    = w_id[g-1];
            assign l_tok   = w_tok[g-1];
            assign l_len   = w_len[g-1];
            assign l_refs  = w_refs[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign rt_valid = 1'b0;
            assign rt_id    = '0;
            assign rt_tok   = '0;
            assign rt_len   = '0;
            assign rt_refs  = '0;
        end else begin : g_body
            assign rt_valid = w_valid[g+1];
            assign rt_id    = w_id[g+1];
            assign rt_tok   = w_tok[g+1];
            assign rt_len   = w_len[g+1];
            assign rt_refs  = w_refs[g+1];
        end

        midtt_cell #(
            .TW(TW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_key_id  (r_id),
            .i_key_tok (r_tok),
            .i_key_len (r_len),
            .i_chain   (w_chain[g]),
            .o_chain   (w_chain[g+1]),
            .i_l_valid (l_valid),
            .i_l_id    (l_id),
            .i_l_tok   (l_tok),
            .i_l_len   (l_len),
            .i_l_refs  (l_refs),
            .i_r_valid (rt_valid),
            .i_r_id    (rt_id),
            .i_r_tok   (rt_tok),
            .i_r_len   (rt_len),
            .i_r_refs  (rt_refs),
            .o_valid   (w_valid[g]),
            .o_id      (w_id[g]),
            .o_tok     (w_tok[g]),
            .o_len     (w_len[g]),
            .o_refs    (w_refs[g])
        );
    end

    always_comb begin
        n_status   = ST_NOTFOUND;
        n_found_id = '0;
        n_count    = r_count;
        unique case (r_op)
            OP_INSERT: begin
                if (chain_end.id_seen) begin
                    n_status   = chain_end.tok_same ? ST_RETX : ST_REPLACED;
                    n_found_id = r_id;
                end else if (ctl.full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status   = ST_NEW;
                    n_found_id = r_id;
                    n_count    = r_count + CW'(1);
                end
            end
            OP_LOOKUP, OP_RELEASE: begin
                if (chain_end.tok_seen) begin
                    n_status   = ST_FOUND;
                    n_found_id = chain_end.hit_id;
                    if (r_op == OP_RELEASE && chain_end.rm) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_status = ST_NOTFOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_id  <= i_msg_id;
            r_tok <= n_tok;
            r_len <= i_token_len;
        end
        if (go) begin
            r_status   <= n_status;
            r_found_id <= n_found_id;
            r_occ      <= OCC_W'(n_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_found_id  = r_found_id;
    assign o_occupancy = r_occ;

endmodule

### dv/tb_top.sv
module tb_top;
    import midtt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int STUCK_LIMIT = 2000;
    localparam int ID_POOL_N   = 20;
    localparam int TOK_POOL_N  = 12;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RX_NONE    = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     found_id;
        logic [OCC_W-1:0]    occupancy;
    } t_table_reply;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic [OP_W-1:0]     i_op          = OP_INSERT;
    logic [ID_W-1:0]     i_msg_id      = '0;
    logic [IN_TOK_W-1:0] i_token_bytes = '0;
    logic [LEN_W-1:0]    i_token_len   = '0;
    logic                i_stall       = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_found_id;
    logic [OCC_W-1:0]    o_occupancy;

    // predicted table contents, newest first
    logic [ID_W-1:0]     tbl_id   [DEPTH];
    logic [IN_TOK_W-1:0] tbl_tok  [DEPTH];
    logic [LEN_W-1:0]    tbl_len  [DEPTH];
    logic [REFS_W-1:0]   tbl_refs [DEPTH];
    int                  tbl_count = 0;

    t_table_reply expected_replies[$];
    t_table_reply seen_exp;

    logic [ID_W-1:0]     id_pool  [ID_POOL_N];
    logic [IN_TOK_W-1:0] tok_pool [TOK_POOL_N];
    logic [LEN_W-1:0]    len_pool [TOK_POOL_N];

    int fail_count    = 0;
    int stuck_cycles  = 0;
    int burst_left    = 0;
    int tx_gap_max    = 0;
    int rx_mode       = RX_NONE;
    int hold_request  = 0;

    message_id_token_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_msg_id      (i_msg_id),
        .i_token_bytes (i_token_bytes),
        .i_token_len   (i_token_len),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found_id    (o_found_id),
        .o_occupancy   (o_occupancy)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [IN_TOK_W-1:0] token_keep_mask(input logic [LEN_W-1:0] len);
        int n;
        n = (len < 8) ? int'(len) : 8;
        if (n >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic t_table_reply apply_table_op(input logic [OP_W-1:0] op,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [IN_TOK_W-1:0] tok,
                                                    input logic [LEN_W-1:0] len);
        t_table_reply r;
        logic [IN_TOK_W-1:0] tk;
        int hit;
        int j;
        tk = tok & token_keep_mask(len);
        r.status = ST_NOTFOUND;
        r.found_id = '0;
        hit = -1;
        if (op == OP_INSERT) begin
            for (j = 0; j < tbl_count; j++) begin
                if (hit < 0 && tbl_id[j] == id) begin
                    hit = j;
                end
            end
            if (hit >= 0) begin
                r.found_id = id;
                if (tbl_len[hit] == len && tbl_tok[hit] == tk) begin
                    if (tbl_refs[hit] != REFS_MAX) begin
                        tbl_refs[hit] = tbl_refs[hit] + REFS_ONE;
                    end
                    r.status = ST_RETX;
                end else begin
                    tbl_tok[hit] = tk;
                    tbl_len[hit] = len;
                    tbl_refs[hit] = REFS_ONE;
                    r.status = ST_REPLACED;
                end
            end else if (tbl_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (j = tbl_count; j > 0; j--) begin
                    tbl_id[j] = tbl_id[j-1];
                    tbl_tok[j] = tbl_tok[j-1];
                    tbl_len[j] = tbl_len[j-1];
                    tbl_refs[j] = tbl_refs[j-1];
                end
                tbl_id[0] = id;
                tbl_tok[0] = tk;
                tbl_len[0] = len;
                tbl_refs[0] = REFS_ONE;
                tbl_count++;
                r.status = ST_NEW;
                r.found_id = id;
            end
        end else if (op == OP_LOOKUP || op == OP_RELEASE) begin
            for (j = 0; j < tbl_count; j++) begin
                if (hit < 0 && tbl_len[j] == len && tbl_tok[j] == tk) begin
                    hit = j;
                end
            end
            if (hit >= 0) begin
                r.status = ST_FOUND;
                r.found_id = tbl_id[hit];
                if (op == OP_RELEASE) begin
                    if (tbl_refs[hit] <= REFS_ONE) begin
                        for (j = hit; j < tbl_count - 1; j++) begin
                            tbl_id[j] = tbl_id[j+1];
                            tbl_tok[j] = tbl_tok[j+1];
                            tbl_len[j] = tbl_len[j+1];
                            tbl_refs[j] = tbl_refs[j+1];
                        end
                        tbl_count--;
                    end else begin
                        tbl_refs[hit] = tbl_refs[hit] - REFS_ONE;
                    end
                end
            end
        end
        r.occupancy = tbl_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic logic [IN_TOK_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // fill the bytes past the length with junk that must be ignored
    function automatic logic [IN_TOK_W-1:0] add_junk(input logic [IN_TOK_W-1:0] tok,
                                                     input logic [LEN_W-1:0] len);
        logic [IN_TOK_W-1:0] m;
        m = token_keep_mask(len);
        return (tok & m) | (rand64() & ~m);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [IN_TOK_W-1:0] tok, input logic [LEN_W-1:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_op          <= op;
        i_msg_id      <= id;
        i_token_bytes <= tok;
        i_token_len   <= len;
        do @(posedge i_clk); while (o_stall);
        expected_replies.push_back(apply_table_op(op, id, tok, len));
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int r;
        int k;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [IN_TOK_W-1:0] tok;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, TOK_POOL_N - 1);
        id = id_pool[$urandom_range(0, ID_POOL_N - 1)];
        tok = tok_pool[k];
        len = len_pool[k];
        if (r < 35) begin
            op = OP_INSERT;
            if ($urandom_range(0, 19) == 0) begin
                id = ID_W'($urandom);
                tok = rand64();
                len = LEN_W'($urandom_range(0, 15));
            end
        end else if (r < 95) begin
            op = (r < 55) ? OP_LOOKUP : OP_RELEASE;
            id = ID_W'($urandom);
            if (tbl_count > 0 && $urandom_range(0, 9) < 8) begin
                k = $urandom_range(0, tbl_count - 1);
                tok = tbl_tok[k];
                len = tbl_len[k];
            end
        end else begin
            op = OP_UNUSED;
            id = ID_W'($urandom);
        end
        send_item(op, id, add_junk(tok, len), len);
    endtask

    task automatic test_basic_ops();
        logic [IN_TOK_W-1:0] t;
        tx_gap_max = 2;
        rx_mode = RX_RANDOM;
        send_item(OP_INSERT, 16'h0000, 64'h0, 4'd0);
        send_item(OP_INSERT, 16'hFFFF, '1, 4'd8);
        send_item(OP_INSERT, 16'hFFFF, '1, 4'd8);
        send_item(OP_INSERT, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 4'd8);
        send_item(OP_INSERT, 16'h1234, 64'hDEAD_BEEF_00C0_FFEE, 4'd3);
        send_item(OP_LOOKUP, 16'hFFFF, 64'h5555_5555_55C0_FFEE, 4'd3);
        send_item(OP_LOOKUP, 16'h0000, rand64(), 4'd0);
        send_item(OP_LOOKUP, 16'h0000, 64'h0123_4567_89AB_CDEE, 4'd8);
        // lengths beyond the byte count
        t = rand64();
        send_item(OP_INSERT, 16'h00A5, t, 4'd12);
        send_item(OP_LOOKUP, 16'h0000, t, 4'd12);
        send_item(OP_LOOKUP, 16'h0000, t, 4'd8);
        send_item(OP_LOOKUP, 16'h0000, t, 4'd15);
        send_item(OP_UNUSED, 16'hFFFF, '1, 4'd15);
        send_item(OP_RELEASE, 16'h0000, 64'hAAAA_AAAA_AAC0_FFEE, 4'd3);
        send_item(OP_LOOKUP, 16'h0000, 64'hDEAD_BEEF_00C0_FFEE, 4'd3);
        send_item(OP_INSERT, 16'h0001, 64'h0000_0000_0000_3C5A, 4'd2);
        send_item(OP_INSERT, 16'h0001, 64'hFFFF_FFFF_FFFF_3C5A, 4'd2);
        send_item(OP_RELEASE, 16'h0000, 64'h3C5A, 4'd2);
        send_item(OP_RELEASE, 16'h0000, 64'h3C5A, 4'd2);
        send_item(OP_RELEASE, 16'h0000, 64'h3C5A, 4'd2);
        // same token under two ids, newest wins
        send_item(OP_INSERT, 16'h0010, 64'h77, 4'd1);
        send_item(OP_INSERT, 16'h0020, 64'h77, 4'd1);
        send_item(OP_LOOKUP, 16'h0000, 64'h77, 4'd1);
        wait_until_drained();
    endtask

    task automatic test_table_full();
        logic [ID_W-1:0] nid;
        tx_gap_max = 0;
        rx_mode = RX_NONE;
        nid = 16'h4000;
        while (tbl_count < DEPTH) begin
            send_item(OP_INSERT, nid, rand64(), LEN_W'($urandom_range(1, 8)));
            nid++;
        end
        send_item(OP_INSERT, 16'h8000, rand64(), 4'd4);
        send_item(OP_INSERT, tbl_id[DEPTH-1], tbl_tok[DEPTH-1], tbl_len[DEPTH-1]);
        send_item(OP_INSERT, tbl_id[0], rand64(), 4'd9);
        // empty the table again, oldest slot first
        while (tbl_count > 0) begin
            send_item(OP_RELEASE, ID_W'($urandom),
                      add_junk(tbl_tok[tbl_count-1], tbl_len[tbl_count-1]),
                      tbl_len[tbl_count-1]);
        end
        send_item(OP_RELEASE, 16'h0000, 64'h0, 4'd0);
        wait_until_drained();
    endtask

    task automatic test_refcount_saturation();
        logic [IN_TOK_W-1:0] t;
        tx_gap_max = 1;
        rx_mode = RX_PATTERN;
        t = rand64();
        repeat (258) send_item(OP_INSERT, 16'h7777, add_junk(t, 4'd5), 4'd5);
        repeat (256) send_item(OP_RELEASE, 16'h0000, add_junk(t, 4'd5), 4'd5);
        wait_until_drained();
    endtask

    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_mode = RX_NONE;
        hold_request = 150;
        repeat (40) send_random_item();
        wait_until_drained();
    endtask

    task automatic test_random_traffic(input int n, input int gap_max, input int rxm);
        tx_gap_max = gap_max;
        rx_mode = rxm;
        repeat (n) send_random_item();
        wait_until_drained();
    endtask

    // receiver stall pattern
    initial begin : rx_stall_gen
        int period;
        int on_len;
        int phase_cnt;
        period = 8;
        on_len = 3;
        phase_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                i_stall <= 1'b1;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
                i_stall <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_NONE: i_stall <= 1'b0;
                    RX_RANDOM: i_stall <= ($urandom_range(0, 99) < 35);
                    default: begin
                        i_stall <= (phase_cnt < on_len);
                        phase_cnt++;
                        if (phase_cnt >= period) begin
                            phase_cnt = 0;
                            period = $urandom_range(2, 16);
                            on_len = $urandom_range(0, period - 1);
                        end
                    end
                endcase
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_replies.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected transfer status=%0d found_id=%h occupancy=%0d",
                         $time, o_status, o_found_id, o_occupancy);
            end else begin
                seen_exp = expected_replies.pop_front();
                if (o_status !== seen_exp.status) begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, seen_exp.status, o_status);
                end
                if (o_found_id !== seen_exp.found_id) begin
                    fail_count++;
                    $display("%0t: found_id expected %h actual %h",
                             $time, seen_exp.found_id, o_found_id);
                end
                if (o_occupancy !== seen_exp.occupancy) begin
                    fail_count++;
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, seen_exp.occupancy, o_occupancy);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("** message_id_token_table_core: FAILED **");
            $finish;
        end
    end

    initial begin : main_seq
        int i;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (i = 2; i < ID_POOL_N; i++) begin
            id_pool[i] = ID_W'($urandom);
        end
        for (i = 0; i < TOK_POOL_N; i++) begin
            len_pool[i] = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(1, 8))
                                                     : LEN_W'($urandom_range(0, 15));
            tok_pool[i] = rand64() & token_keep_mask(len_pool[i]);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_table_full();
        test_refcount_saturation();
        test_backpressure();
        test_random_traffic(400, 0, RX_NONE);
        test_random_traffic(400, 6, RX_RANDOM);
        test_random_traffic(400, 3, RX_PATTERN);
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** message_id_token_table_core: PASSED **");
        end else begin
            $display("** message_id_token_table_core: FAILED **");
        end
        $finish;
    end

endmodule
